>>> rtl/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg
// Opcodes, status codes and register indexes of the bounded integer set.
// ----------------------------------------------------------------------------
package bis_pkg;

   localparam int OPCODE_W = 3;
   localparam int STATUS_W = 3;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 4;
   localparam int CAP_W    = 4;

   localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_QUERY  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_REWIND = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_NEXT   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ABSENT    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;

   // register indexes on the configuration port (byte address = 4 * index)
   localparam logic [1:0] CSR_IDX_CAPACITY = 2'd0;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 4'd8;

endpackage

>>> rtl/bis_req_if.sv
// ----------------------------------------------------------------------------
// bis_req_if
// Request channel: opcode and value with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bis_req_if;
   import bis_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [OPCODE_W-1:0]        opcode;
   logic signed [VALUE_W-1:0]  value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);

endinterface

>>> rtl/bis_rsp_if.sv
// ----------------------------------------------------------------------------
// bis_rsp_if
// Response channel: status, membership, element, count and cursor flag.
// ----------------------------------------------------------------------------
interface bis_rsp_if;
   import bis_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [STATUS_W-1:0]        status;
   logic                       found;
   logic signed [VALUE_W-1:0]  element;
   logic [COUNT_W-1:0]         count;
   logic                       more;

   modport source (output valid, output status, output found, output element,
                   output count, output more, input ready);
   modport sink   (input valid, input status, input found, input element,
                   input count, input more, output ready);

endinterface

>>> rtl/bounded_integer_set.sv
// ----------------------------------------------------------------------------
// bounded_integer_set
// Set of distinct signed 32-bit values kept compacted in insertion order in a
// synchronous RAM with one read and one write port, with membership search,
// shift-down removal and a walk cursor.
// ----------------------------------------------------------------------------
// One request is in work at a time: a new one is taken only in the idle
// state, after the response to the last one has been registered. Query and
// insert read and compare the entries in turn until a match or the end of
// the set; remove, when found, then shifts each later entry down one place.
// The read-compare loop over the entry RAM (one read port, registered read)
// sets the rate.
// Synchronous reset clears the count, the cursor and the control state and
// sets capacity to 8; the entry RAM is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module bounded_integer_set #(
   parameter int MAX_ELEMENTS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   bis_req_if.sink                  req_ch,
   bis_rsp_if.source                rsp_ch,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [1:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);
   import bis_pkg::*;

   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int LW = (CW > CAP_W) ? CW : CAP_W;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_RD     = 8'b0000_0010,
      S_CMP    = 8'b0000_0100,
      S_DECIDE = 8'b0000_1000,
      S_SH_RD  = 8'b0001_0000,
      S_SH_WR  = 8'b0010_0000,
      S_NEXT   = 8'b0100_0000,
      S_RESP   = 8'b1000_0000
   } state_type;

   // entry RAM
   logic [VALUE_W-1:0] mem [0:MAX_ELEMENTS-1];
   logic [VALUE_W-1:0] mem_rdata_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [AW-1:0]      mem_raddr;
   logic [VALUE_W-1:0] mem_wdata;

   state_type          state_ff, state_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic [CW-1:0]      cursor_ff, cursor_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      idx_inc;
   logic [CAP_W-1:0]   capacity_ff, capacity_in;
   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic               found_ff, found_in;
   logic [VALUE_W-1:0] element_ff, element_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [VALUE_W-1:0] rsp_element_ff, rsp_element_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_more_ff, rsp_more_in;

   logic               csr_write;
   logic               csr_hit;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr >> 2) == CSR_IDX_CAPACITY;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? 32'(capacity_ff) : 32'd0;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_write && csr_hit) begin
         capacity_in = csr_pwdata[CAP_W-1:0];
      end
   end

   assign idx_inc = idx_ff + 1'b1;

   assign req_ch.ready   = (state_ff == S_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.status  = rsp_status_ff;
   assign rsp_ch.found   = rsp_found_ff;
   assign rsp_ch.element = rsp_element_ff;
   assign rsp_ch.count   = rsp_count_ff;
   assign rsp_ch.more    = rsp_more_ff;

   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      cursor_in      = cursor_ff;
      idx_in         = idx_ff;
      op_in          = op_ff;
      value_in       = value_ff;
      status_in      = status_ff;
      found_in       = found_ff;
      element_in     = element_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_element_in = rsp_element_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_more_in    = rsp_more_ff;
      mem_we         = 1'b0;
      mem_waddr      = idx_ff[AW-1:0];
      mem_wdata      = value_ff;
      mem_raddr      = idx_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in      = req_ch.opcode;
               value_in   = req_ch.value;
               idx_in     = '0;
               status_in  = ST_DONE;
               found_in   = 1'b0;
               element_in = '0;
               case (req_ch.opcode)
                  OP_INSERT, OP_REMOVE, OP_QUERY: begin
                     state_in = S_RD;
                  end
                  OP_REWIND: begin
                     cursor_in = '0;
                     state_in  = S_RESP;
                  end
                  OP_NEXT: begin
                     if (cursor_ff < fill_ff) begin
                        mem_raddr = cursor_ff[AW-1:0];
                        state_in  = S_NEXT;
                     end else begin
                        status_in = ST_EXHAUSTED;
                        state_in  = S_RESP;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_RD: begin
            if (idx_ff < fill_ff) begin
               state_in = S_CMP;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_CMP: begin
            // hold idx at the matching slot for removal
            if (mem_rdata_ff == value_ff) begin
               found_in = 1'b1;
               state_in = S_DECIDE;
            end else begin
               idx_in   = idx_inc;
               state_in = S_RD;
            end
         end
         S_DECIDE: begin
            state_in = S_RESP;
            case (op_ff)
               OP_INSERT: begin
                  if (found_ff) begin
                     status_in = ST_PRESENT;
                  end else if (fill_ff < MAX_CNT && LW'(fill_ff) < LW'(capacity_ff)) begin
                     mem_we    = 1'b1;
                     mem_waddr = fill_ff[AW-1:0];
                     fill_in   = fill_ff + 1'b1;
                  end else begin
                     status_in = ST_FULL;
                  end
               end
               OP_REMOVE: begin
                  if (found_ff) begin
                     state_in = S_SH_RD;
                  end else begin
                     status_in = ST_ABSENT;
                  end
               end
               OP_QUERY: begin
                  if (!found_ff) begin
                     status_in = ST_ABSENT;
                  end
               end
               default: begin
                  status_in = ST_DONE;
               end
            endcase
         end
         S_SH_RD: begin
            if (idx_inc < fill_ff) begin
               mem_raddr = idx_inc[AW-1:0];
               state_in  = S_SH_WR;
            end else begin
               fill_in  = fill_ff - 1'b1;
               state_in = S_RESP;
            end
         end
         S_SH_WR: begin
            // move the later entry down one place
            mem_we    = 1'b1;
            mem_waddr = idx_ff[AW-1:0];
            mem_wdata = mem_rdata_ff;
            idx_in    = idx_inc;
            state_in  = S_SH_RD;
         end
         S_NEXT: begin
            element_in = mem_rdata_ff;
            cursor_in  = cursor_ff + 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_found_in   = found_ff;
               rsp_element_in = element_ff;
               rsp_count_in   = COUNT_W'(fill_ff);
               rsp_more_in    = cursor_ff < fill_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         cursor_ff    <= '0;
         capacity_ff  <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cursor_ff    <= cursor_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      op_ff          <= op_in;
      value_ff       <= value_in;
      status_ff      <= status_in;
      found_ff       <= found_in;
      element_ff     <= element_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_element_ff <= rsp_element_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_more_ff    <= rsp_more_in;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= MAX_CNT)
      else $error("fill count exceeds store depth");

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= MAX_CNT)
      else $error("cursor exceeds store depth");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff != S_IDLE))
      else $error("request transfer did not start work");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_DECIDE || state_ff == S_SH_WR))
      else $error("entry RAM written outside insert or shift");

   a_shift_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SH_WR) |=> $stable(fill_ff))
      else $error("count changed during shift");

endmodule
